// File: src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants for the linear-probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int MIN_SLOTS  = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int HASH_BITS  = 32;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_GET    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_FIRST  = 3'd4,
    CMD_LAST   = 3'd5,
    CMD_NEXT   = 3'd6,
    CMD_PREV   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_FILLED = 2'd1;
  localparam logic [1:0] KIND_TOMB   = 2'd2;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_BITS-1:0]  key_hash;
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_W-1:0]     from_slot;
  } in_word_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic [KEY_BITS-1:0]   found_key;
    logic [VALUE_BITS-1:0] found_value;
    logic [CNT_W-1:0]      fill;
    logic [CNT_W-1:0]      table_size;
  } out_word_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [HASH_BITS-1:0]  hash;
  } entry_t;

endpackage

// File: src/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table, linear probing with tombstones, auto resize.
// ----------------------------------------------------------------------------
// Get/remove/insert walk the probe chain from the key's hash slot, issuing
//   one slot read per cycle from the slot-kind and entry RAMs.
// Clear and first/last/next/prev visit up to table_size slots.
// A grow or shrink gathers filled entries into scratch, clears, and re-inserts each.
// One word in flight at a time; the result register lets the next word in.
// After reset a clearing pass over all 1024 slots runs (not ready).
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_COMPACT = 9'b000000100,
    S_CLR     = 9'b000001000,
    S_REIN_RD = 9'b000010000,
    S_REIN_LD = 9'b000100000,
    S_PROBE   = 9'b001000000,
    S_SCAN    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  cmd_t                  cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [HASH_BITS-1:0]  hash_r, hash_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  entry_t                re_r, re_nxt;

  logic [CNT_W-1:0]  size_r, size_nxt, fill_r, fill_nxt, ns_r, ns_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt, cnt_r, cnt_nxt, j_r, j_nxt, clr_r, clr_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt, cur_r, cur_nxt, tomb_r, tomb_nxt;
  logic              v_r, v_nxt, down_r, down_nxt, tomb_v_r, tomb_v_nxt;
  logic              boot_r, boot_nxt, rein_r, rein_nxt;

  status_t               res_st_r, res_st_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic [KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;

  logic      out_v_r, out_v_nxt;
  out_word_t out_r, out_nxt;

  // memory ports
  logic              kind_we, data_we, scr_we;
  logic [SLOT_W-1:0] kind_wa, data_wa, scr_wa;
  logic [1:0]        kind_wd, kind_q;
  entry_t            data_wd, data_q, scr_wd, scr_q;

  lpht_ram #(.WIDTH(2), .DEPTH(MAX_SLOTS)) u_kind_ram (
    .clk(clk), .wr_en(kind_we), .wr_addr(kind_wa), .wr_data(kind_wd),
    .rd_addr(ptr_r), .rd_data(kind_q)
  );

  lpht_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SLOTS)) u_data_ram (
    .clk(clk), .wr_en(data_we), .wr_addr(data_wa), .wr_data(data_wd),
    .rd_addr(ptr_r), .rd_data(data_q)
  );

  lpht_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SLOTS)) u_scr_ram (
    .clk(clk), .wr_en(scr_we), .wr_addr(scr_wa), .wr_data(scr_wd),
    .rd_addr(j_r[SLOT_W-1:0]), .rd_data(scr_q)
  );

  logic [CNT_W-1:0]  size_m1, from_w, nx_start, pv_start, clr_last;
  logic [SLOT_W-1:0] mask;
  logic [CNT_W+1:0]  fill4, size3, size1;
  logic              grow, shrink;
  logic [KEY_BITS-1:0] cmp_key;
  logic              p_stop, p_ok, p_hit;
  logic [SLOT_W-1:0] p_slot;

  always_comb begin
    size_m1  = size_r - 1'b1;
    mask     = size_m1[SLOT_W-1:0];
    from_w   = CNT_W'(in_data.from_slot);
    nx_start = from_w + 1'b1;
    pv_start = (from_w < size_r) ? from_w : size_r;
    fill4    = {fill_r, 2'b00};
    size1    = {2'b00, size_r};
    size3    = {1'b0, size_r, 1'b0} + size1;
    grow     = (fill4 >= size3) && (size_r < CNT_W'(MAX_SLOTS));
    shrink   = (size_r > CNT_W'(MIN_SLOTS)) && (fill4 <= size1);
    clr_last = (boot_r ? CNT_W'(MAX_SLOTS) : size_r) - 1'b1;
    cmp_key  = rein_r ? re_r.key : key_r;

    // probe evaluation of the slot read last cycle
    p_stop = 1'b0;
    p_ok   = 1'b0;
    p_hit  = 1'b0;
    p_slot = cur_r;
    if (v_r && kind_q == KIND_EMPTY) begin
      p_stop = 1'b1;
      p_ok   = 1'b1;
      p_slot = tomb_v_r ? tomb_r : cur_r;
    end else if (v_r && kind_q == KIND_FILLED && data_q.key == cmp_key) begin
      p_stop = 1'b1;
      p_ok   = 1'b1;
      p_hit  = 1'b1;
    end else if (!v_r && rem_r == '0) begin
      p_stop = 1'b1;
      p_ok   = tomb_v_r;
      p_slot = tomb_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    hash_nxt     = hash_r;
    val_nxt      = val_r;
    re_nxt       = re_r;
    size_nxt     = size_r;
    fill_nxt     = fill_r;
    ns_nxt       = ns_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    j_nxt        = j_r;
    clr_nxt      = clr_r;
    ptr_nxt      = ptr_r;
    cur_nxt      = cur_r;
    tomb_nxt     = tomb_r;
    v_nxt        = 1'b0;
    down_nxt     = down_r;
    tomb_v_nxt   = tomb_v_r;
    boot_nxt     = boot_r;
    rein_nxt     = rein_r;
    res_st_nxt   = res_st_r;
    res_slot_nxt = res_slot_r;
    res_key_nxt  = res_key_r;
    res_val_nxt  = res_val_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;

    kind_we = 1'b0;
    kind_wa = cur_r;
    kind_wd = KIND_EMPTY;
    data_we = 1'b0;
    data_wa = p_slot;
    data_wd = re_r;
    scr_we  = 1'b0;
    scr_wa  = cnt_r[SLOT_W-1:0];
    scr_wd  = data_q;

    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end

    // walk engine: one slot read issued per cycle while reads remain
    if (state_r == S_PROBE || state_r == S_SCAN || state_r == S_COMPACT) begin
      if (rem_r != '0) begin
        v_nxt   = 1'b1;
        cur_nxt = ptr_r;
        rem_nxt = rem_r - 1'b1;
        ptr_nxt = down_r ? ptr_r - 1'b1 : ((ptr_r + 1'b1) & mask);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_data.cmd;
          key_nxt      = in_data.key;
          hash_nxt     = in_data.key_hash;
          val_nxt      = in_data.value;
          res_st_nxt   = ST_NONE;
          res_slot_nxt = '0;
          res_key_nxt  = '0;
          res_val_nxt  = '0;
          rein_nxt     = 1'b0;
          tomb_v_nxt   = 1'b0;
          down_nxt     = 1'b0;
          rem_nxt      = size_r;
          ptr_nxt      = in_data.key_hash[SLOT_W-1:0] & mask;
          unique case (in_data.cmd)
            CMD_INSERT: state_nxt = S_CHECK;
            CMD_GET, CMD_REMOVE: state_nxt = S_PROBE;
            CMD_CLEAR: begin
              fill_nxt   = '0;
              clr_nxt    = '0;
              res_st_nxt = ST_OK;
              state_nxt  = S_CLR;
            end
            CMD_FIRST: begin
              ptr_nxt   = '0;
              rem_nxt   = (fill_r != '0) ? size_r : '0;
              state_nxt = S_SCAN;
            end
            CMD_LAST: begin
              ptr_nxt   = mask;
              rem_nxt   = (fill_r != '0) ? size_r : '0;
              down_nxt  = 1'b1;
              state_nxt = S_SCAN;
            end
            CMD_NEXT: begin
              ptr_nxt   = nx_start[SLOT_W-1:0];
              rem_nxt   = (nx_start >= size_r) ? '0 : size_r - nx_start;
              state_nxt = S_SCAN;
            end
            CMD_PREV: begin
              ptr_nxt   = SLOT_W'(pv_start - 1'b1);
              rem_nxt   = pv_start;
              down_nxt  = 1'b1;
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_CHECK: begin
        ptr_nxt    = '0;
        rem_nxt    = size_r;
        cnt_nxt    = '0;
        down_nxt   = 1'b0;
        tomb_v_nxt = 1'b0;
        if (cmd_r == CMD_INSERT) begin
          if (grow) begin
            ns_nxt    = {size_r[CNT_W-2:0], 1'b0};
            state_nxt = S_COMPACT;
          end else begin
            ptr_nxt   = hash_r[SLOT_W-1:0] & mask;
            rein_nxt  = 1'b0;
            state_nxt = S_PROBE;
          end
        end else if (shrink) begin
          ns_nxt    = size_r >> 1;
          state_nxt = S_COMPACT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // gather filled entries into scratch in slot order
      S_COMPACT: begin
        if (v_r && kind_q == KIND_FILLED) begin
          scr_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (!v_r && rem_r == '0) begin
          size_nxt  = ns_r;
          fill_nxt  = '0;
          clr_nxt   = '0;
          rein_nxt  = 1'b1;
          state_nxt = S_CLR;
        end
      end

      S_CLR: begin
        kind_we = 1'b1;
        kind_wa = clr_r[SLOT_W-1:0];
        kind_wd = KIND_EMPTY;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == clr_last) begin
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else if (rein_r) begin
            j_nxt     = '0;
            state_nxt = S_REIN_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_REIN_RD: begin
        state_nxt = (j_r == cnt_r) ? S_CHECK : S_REIN_LD;
      end

      S_REIN_LD: begin
        re_nxt     = scr_q;
        ptr_nxt    = scr_q.hash[SLOT_W-1:0] & mask;
        rem_nxt    = size_r;
        tomb_v_nxt = 1'b0;
        down_nxt   = 1'b0;
        j_nxt      = j_r + 1'b1;
        state_nxt  = S_PROBE;
      end

      S_PROBE: begin
        if (v_r && kind_q == KIND_TOMB && !tomb_v_r) begin
          tomb_v_nxt = 1'b1;
          tomb_nxt   = cur_r;
        end
        if (p_stop) begin
          kind_wa = p_slot;
          if (rein_r) begin
            if (p_ok && !p_hit) begin
              kind_we  = 1'b1;
              kind_wd  = KIND_FILLED;
              data_we  = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
            state_nxt = S_REIN_RD;
          end else begin
            state_nxt = S_DONE;
            case (cmd_r)
              CMD_INSERT: begin
                if (!p_ok) begin
                  res_st_nxt = ST_FULL;
                end else if (p_hit) begin
                  res_st_nxt   = ST_DUP;
                  res_slot_nxt = p_slot;
                  res_key_nxt  = data_q.key;
                  res_val_nxt  = data_q.value;
                end else begin
                  kind_we      = 1'b1;
                  kind_wd      = KIND_FILLED;
                  data_we      = 1'b1;
                  data_wd      = '{key: key_r, value: val_r, hash: hash_r};
                  fill_nxt     = fill_r + 1'b1;
                  res_st_nxt   = ST_OK;
                  res_slot_nxt = p_slot;
                  res_key_nxt  = key_r;
                  res_val_nxt  = val_r;
                end
              end
              CMD_GET: begin
                if (p_hit) begin
                  res_st_nxt   = ST_OK;
                  res_slot_nxt = p_slot;
                  res_key_nxt  = data_q.key;
                  res_val_nxt  = data_q.value;
                end
              end
              CMD_REMOVE: begin
                if (p_hit) begin
                  kind_we      = 1'b1;
                  kind_wd      = KIND_TOMB;
                  fill_nxt     = fill_r - 1'b1;
                  res_st_nxt   = ST_OK;
                  res_slot_nxt = p_slot;
                  res_key_nxt  = data_q.key;
                  res_val_nxt  = data_q.value;
                  state_nxt    = S_CHECK;
                end
              end
              default: state_nxt = S_DONE;
            endcase
          end
        end
      end

      S_SCAN: begin
        if (v_r && kind_q == KIND_FILLED) begin
          res_st_nxt   = ST_OK;
          res_slot_nxt = cur_r;
          res_key_nxt  = data_q.key;
          res_val_nxt  = data_q.value;
          state_nxt    = S_DONE;
        end else if (!v_r && rem_r == '0) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_v_r || out_ready) begin
          out_v_nxt = 1'b1;
          out_nxt   = '{status: res_st_r, slot: res_slot_r, found_key: res_key_r,
                        found_value: res_val_r, fill: fill_r, table_size: size_r};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      boot_r   <= 1'b1;
      rein_r   <= 1'b0;
      clr_r    <= '0;
      size_r   <= CNT_W'(MIN_SLOTS);
      fill_r   <= '0;
      v_r      <= 1'b0;
      rem_r    <= '0;
      cnt_r    <= '0;
      j_r      <= '0;
      tomb_v_r <= 1'b0;
      down_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      boot_r   <= boot_nxt;
      rein_r   <= rein_nxt;
      clr_r    <= clr_nxt;
      size_r   <= size_nxt;
      fill_r   <= fill_nxt;
      v_r      <= v_nxt;
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_nxt;
      j_r      <= j_nxt;
      tomb_v_r <= tomb_v_nxt;
      down_r   <= down_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    hash_r     <= hash_nxt;
    val_r      <= val_nxt;
    re_r       <= re_nxt;
    ns_r       <= ns_nxt;
    ptr_r      <= ptr_nxt;
    cur_r      <= cur_nxt;
    tomb_r     <= tomb_nxt;
    res_st_r   <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    res_key_r  <= res_key_nxt;
    res_val_r  <= res_val_nxt;
    out_r      <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_fill_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= size_r)
    else $error("fill exceeds table size");

  a_size_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(size_r))
    else $error("table size not a power of two");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    size_r >= CNT_W'(MIN_SLOTS) && size_r <= CNT_W'(MAX_SLOTS))
    else $error("table size out of range");

  a_rein_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REIN_RD |-> j_r <= cnt_r)
    else $error("rehash index ran past scratch count");

endmodule
